[rtl/core/dfr_pkg.sv]
// Shared types and constants for the depth frame reassembler.
// Used by dfr_cfg_regs, dfr_core and depth_frame_reassembler_top; no dependencies.
`default_nettype none

package dfr_pkg;

    // Default sizing of the slot ring and the fill counter.
    localparam int DEF_SLOTS     = 32;
    localparam int DEF_FILL_BITS = 24;

    // Fixed field widths of the beats.
    localparam int LEN_W    = 16;
    localparam int MAGIC_W  = 8;
    localparam int IMG_W    = 32;
    localparam int SUBSEQ_W = 16;
    localparam int SLOT_W   = 5;
    localparam int OFFS_W   = 24;
    localparam int CAP_W    = 24;

    // Footer codes.
    localparam logic [SUBSEQ_W-1:0] END_SUBSEQ   = 16'd9;
    localparam logic [MAGIC_W-1:0]  FOOTER_MAGIC = 8'h00;

    // Register map.
    localparam int          CFG_ADDR_W     = 3;
    localparam logic        REG_IMAGE_SIZE = 1'b0;
    localparam logic        REG_FRAME_CAP  = 1'b1;
    localparam logic [CAP_W-1:0] CAP_RESET = 24'hFFFFFF;

    // Configuration values seen by the datapath.
    typedef struct packed {
        logic [IMG_W-1:0] image_size;
        logic [CAP_W-1:0] frame_capacity;
    } dfr_cfg_t;

    // One result beat.
    typedef struct packed {
        logic              append_ok;
        logic [SLOT_W-1:0] write_slot;
        logic [OFFS_W-1:0] write_offset;
        logic              frame_done;
        logic [SLOT_W-1:0] done_slot;
        logic [OFFS_W-1:0] done_length;
        logic              overrun;
        logic              bad_footer;
        logic              in_sync;
    } dfr_result_t;

endpackage

`default_nettype wire

[rtl/core/dfr_cfg_regs.sv]
// APB-style configuration registers: image size and frame capacity.
// Depends on dfr_pkg for the register map and the dfr_cfg_t struct.
`default_nettype none

module dfr_cfg_regs
    import dfr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output dfr_cfg_t                   cfg
);

    logic [IMG_W-1:0] image_size_reg;
    logic [CAP_W-1:0] frame_cap_reg;
    logic             reg_sel;
    logic             wr_en;

    // Register index is the word address.
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg <= '0;
            frame_cap_reg  <= CAP_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_IMAGE_SIZE: image_size_reg <= pwdata;
                REG_FRAME_CAP:  frame_cap_reg  <= pwdata[CAP_W-1:0];
                default:        image_size_reg <= image_size_reg;
            endcase
        end
    end

    // Read data mux.
    always_comb
    begin
        unique case (reg_sel)
            REG_IMAGE_SIZE: prdata = image_size_reg;
            REG_FRAME_CAP:  prdata = {{(32-CAP_W){1'b0}}, frame_cap_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg = '{image_size: image_size_reg, frame_capacity: frame_cap_reg};

endmodule

`default_nettype wire

[rtl/core/dfr_core.sv]
// Reassembly datapath: input register, one pass of sync/fill/commit logic, result register.
// Depends on dfr_pkg for field widths, footer codes and the cfg/result structs.
`default_nettype none

module dfr_core
    import dfr_pkg::*;
#(
    parameter int SLOTS     = DEF_SLOTS,
    parameter int FILL_BITS = DEF_FILL_BITS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dfr_cfg_t            cfg,
    input  wire logic                pkt_valid,
    output logic                     pkt_stall,
    input  wire logic [LEN_W-1:0]    received_length,
    input  wire logic [LEN_W-1:0]    nominal_length,
    input  wire logic [MAGIC_W-1:0]  footer_magic,
    input  wire logic [IMG_W-1:0]    footer_image_length,
    input  wire logic [SUBSEQ_W-1:0] footer_subsequence,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output dfr_result_t              res
);

    localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SUM_W     = ((FILL_BITS >= CAP_W) ? FILL_BITS : CAP_W) + 1;
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);
    localparam logic [SUM_W-1:0]     FILL_MAX  =
        SUM_W'((64'd1 << FILL_BITS) - 64'd1);

    // Input register.
    logic                s1_valid_reg, s1_valid_next;
    logic [LEN_W-1:0]    rlen_reg;
    logic [LEN_W-1:0]    nlen_reg;
    logic [MAGIC_W-1:0]  magic_reg;
    logic [IMG_W-1:0]    flen_reg;
    logic [SUBSEQ_W-1:0] subseq_reg;

    // Reassembly state.
    logic                 sync_reg, sync_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    logic [FILL_BITS-1:0] fill_reg, fill_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    dfr_result_t result_reg, result_next;

    logic             pkt_take;
    logic             out_free;
    logic             s1_move;
    logic [SUM_W-1:0] cap_eff;
    logic [SUM_W-1:0] fill_sum;

    // Handshake: the result register frees when empty or when its beat is taken.
    assign out_free  = !out_valid_reg || !res_stall;
    assign s1_move   = s1_valid_reg && out_free;
    assign pkt_stall = s1_valid_reg && !out_free;
    assign pkt_take  = pkt_valid && !pkt_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pkt_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Effective capacity is limited by what the fill counter can hold.
    assign cap_eff  = (SUM_W'(cfg.frame_capacity) > FILL_MAX) ? FILL_MAX
                                                              : SUM_W'(cfg.frame_capacity);
    assign fill_sum = SUM_W'(fill_reg) + SUM_W'(rlen_reg);

    // Append, overrun check, then footer check on a closing packet.
    always_comb
    begin
        result_next = '0;
        sync_next   = sync_reg;
        slot_next   = slot_reg;
        fill_next   = fill_reg;

        if (rlen_reg != '0)
        begin
            if (sync_reg)
            begin
                if (fill_sum > cap_eff)
                begin
                    result_next.overrun = 1'b1;
                    sync_next           = 1'b0;
                    fill_next           = '0;
                end
                else
                begin
                    result_next.append_ok    = 1'b1;
                    result_next.write_slot   = SLOT_W'(slot_reg);
                    result_next.write_offset = OFFS_W'(fill_reg);
                    fill_next                = FILL_BITS'(fill_sum);
                end
            end

            if (rlen_reg != nlen_reg)
            begin
                if (magic_reg != FOOTER_MAGIC || flen_reg != cfg.image_size)
                begin
                    result_next.bad_footer = 1'b1;
                    sync_next              = 1'b0;
                    fill_next              = '0;
                end
                else if (subseq_reg == END_SUBSEQ)
                begin
                    // Commit with the fill as left by the append step above.
                    result_next.frame_done  = 1'b1;
                    result_next.done_slot   = SLOT_W'(slot_reg);
                    result_next.done_length = OFFS_W'(fill_next);
                    sync_next               = 1'b1;
                    slot_next               = (slot_reg == LAST_SLOT) ? '0
                                                                      : slot_reg + SLOT_BITS'(1);
                    fill_next               = '0;
                end
            end
        end

        result_next.in_sync = sync_next;
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sync_reg      <= 1'b0;
            slot_reg      <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_move)
            begin
                sync_reg <= sync_next;
                slot_reg <= slot_next;
                fill_reg <= fill_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pkt_take)
        begin
            rlen_reg   <= received_length;
            nlen_reg   <= nominal_length;
            magic_reg  <= footer_magic;
            flen_reg   <= footer_image_length;
            subseq_reg <= footer_subsequence;
        end
        if (s1_move)
        begin
            result_reg <= result_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = result_reg;

endmodule

`default_nettype wire

[rtl/core/depth_frame_reassembler_top.sv]
// Depth frame reassembler: a packet beat goes through the input and result registers.
// Throughput one packet beat per cycle unless res_stall holds the result register;
// the state update loop (fill add, capacity compare, footer check) sets that figure.
// Asynchronous active-low reset clears sync, slot, fill and all valid flags;
// image_size resets to 0 and frame_capacity to 0xFFFFFF.
// Depends on dfr_pkg, dfr_cfg_regs and dfr_core.
`default_nettype none

module depth_frame_reassembler_top
    import dfr_pkg::*;
#(
    parameter int SLOTS     = DEF_SLOTS,
    parameter int FILL_BITS = DEF_FILL_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    // Packet descriptor channel.
    input  wire logic                  pkt_valid,
    output logic                       pkt_stall,
    input  wire logic [LEN_W-1:0]      received_length,
    input  wire logic [LEN_W-1:0]      nominal_length,
    input  wire logic [MAGIC_W-1:0]    footer_magic,
    input  wire logic [IMG_W-1:0]      footer_image_length,
    input  wire logic [SUBSEQ_W-1:0]   footer_subsequence,
    // Result channel.
    output logic                       res_valid,
    input  wire logic                  res_stall,
    output logic                       append_ok,
    output logic      [SLOT_W-1:0]     write_slot,
    output logic      [OFFS_W-1:0]     write_offset,
    output logic                       frame_done,
    output logic      [SLOT_W-1:0]     done_slot,
    output logic      [OFFS_W-1:0]     done_length,
    output logic                       overrun,
    output logic                       bad_footer,
    output logic                       in_sync
);

    dfr_cfg_t    cfg;
    dfr_result_t res;

    // Configuration registers.
    dfr_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Reassembly datapath.
    dfr_core #(
        .SLOTS     (SLOTS),
        .FILL_BITS (FILL_BITS)
    ) u_core (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg),
        .pkt_valid           (pkt_valid),
        .pkt_stall           (pkt_stall),
        .received_length     (received_length),
        .nominal_length      (nominal_length),
        .footer_magic        (footer_magic),
        .footer_image_length (footer_image_length),
        .footer_subsequence  (footer_subsequence),
        .res_valid           (res_valid),
        .res_stall           (res_stall),
        .res                 (res)
    );

    // Result beat fields.
    assign append_ok    = res.append_ok;
    assign write_slot   = res.write_slot;
    assign write_offset = res.write_offset;
    assign frame_done   = res.frame_done;
    assign done_slot    = res.done_slot;
    assign done_length  = res.done_length;
    assign overrun      = res.overrun;
    assign bad_footer   = res.bad_footer;
    assign in_sync      = res.in_sync;

endmodule

`default_nettype wire
